@@ hdl/gbn_pkg.sv @@
package gbn_pkg;

  localparam int unsigned MAX_SEQ_NUM  = 7;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned SEQ_W        = 3;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned WIN_DEPTH    = MAX_SEQ_NUM + 1;

  localparam logic [1:0] REQ_PKT_READY = 2'd0;
  localparam logic [1:0] REQ_FRAME_ARR = 2'd1;
  localparam logic [1:0] REQ_CKSUM_ERR = 2'd2;
  localparam logic [1:0] REQ_TIMEOUT   = 2'd3;

  localparam logic [1:0] KIND_SENT     = 2'd0;
  localparam logic [1:0] KIND_RX_OK    = 2'd1;
  localparam logic [1:0] KIND_RX_DROP  = 2'd2;
  localparam logic [1:0] KIND_REFUSED  = 2'd3;

  typedef logic [SEQ_W-1:0] seq_t;

  // Operands of the shared sequence unit.
  typedef struct packed {
    seq_t a;
    seq_t b;
    seq_t c;
  } gbn_alu_in_t;

  typedef struct packed {
    seq_t a_inc;
    logic between;
  } gbn_alu_out_t;

  function automatic seq_t seq_inc(input seq_t x);
    seq_t r;
    if (x >= SEQ_W'(MAX_SEQ_NUM)) r = '0;
    else r = x + SEQ_W'(1);
    return r;
  endfunction

endpackage

@@ hdl/gbn_ram.sv @@
module gbn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/gbn_seq_alu.sv @@
module gbn_seq_alu import gbn_pkg::*; (
  input  gbn_alu_in_t  op_i,
  output gbn_alu_out_t res_o
);

  // Circular window test: b lies in [a, c) modulo the sequence space.
  always_comb begin
    res_o.a_inc   = seq_inc(op_i.a);
    res_o.between = ((op_i.a <= op_i.b) && (op_i.b < op_i.c)) ||
                    ((op_i.c < op_i.a) && (op_i.a <= op_i.b)) ||
                    ((op_i.b < op_i.c) && (op_i.c < op_i.a));
  end

endmodule

@@ hdl/go_back_n_arq_engine_unit.sv @@
// Channel   Direction  Handshake            Payload
// request   in         start_i / busy_o     req_type_i, pkt_data_i, rx_seq_i, rx_ack_i
// result    out        valid_o (one cycle)  result_kind_o, tx_seq_o, tx_ack_o, tx_data_o,
//                                           window_count_o, net_enable_o, last_o
//
// A packet-ready item shows its result in the cycle after it is accepted; a checksum
// error, or a timeout with an empty window, gives none. A frame arrival runs the release
// loop in ST_REL, stepping the shared sequence unit once per cycle, then shows its result.
// A timeout replays each buffered frame through ST_RD and ST_EMIT, as the window store
// has a registered read port. Reset (rst_ni low, asynchronous) empties the window and
// zeroes the send, oldest and expected numbers; the store itself is not cleared. The
// receiver cannot stall: every result is shown for exactly one cycle with valid_o high.
module go_back_n_arq_engine_unit import gbn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              req_type_i,
  input  logic [PAYLOAD_BITS-1:0] pkt_data_i,
  input  logic [SEQ_W-1:0]        rx_seq_i,
  input  logic [SEQ_W-1:0]        rx_ack_i,
  output logic                    valid_o,
  output logic [1:0]              result_kind_o,
  output logic [SEQ_W-1:0]        tx_seq_o,
  output logic [SEQ_W-1:0]        tx_ack_o,
  output logic [PAYLOAD_BITS-1:0] tx_data_o,
  output logic [CNT_W-1:0]        window_count_o,
  output logic                    net_enable_o,
  output logic                    last_o
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REL  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  seq_t             nsn_q, nsn_d;
  seq_t             oldest_q, oldest_d;
  seq_t             expect_q, expect_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  seq_t             rack_q, rack_d;
  logic [1:0]       kind_q, kind_d;

  logic                    valid_q, valid_d;
  logic [1:0]              okind_q, okind_d;
  seq_t                    oseq_q, oseq_d;
  logic [PAYLOAD_BITS-1:0] odata_q, odata_d;
  logic [CNT_W-1:0]        ocount_q, ocount_d;
  logic                    olast_q, olast_d;

  logic                    accept;
  logic                    full;
  logic                    ram_we;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic [CNT_W-1:0]        idx_next;
  gbn_alu_in_t             alu_in;
  gbn_alu_out_t            alu_out;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign full     = (count_q >= CNT_W'(MAX_SEQ_NUM));
  assign ram_we   = accept && (req_type_i == REQ_PKT_READY) && !full;
  assign idx_next = idx_q + CNT_W'(1);

  // The one sequence unit serves the release walk (from the oldest unacked
  // number) and every advance of the send number.
  always_comb begin
    alu_in.a = (state_q == ST_REL) ? oldest_q : nsn_q;
    alu_in.b = rack_q;
    alu_in.c = nsn_q;
  end

  gbn_seq_alu u_alu (
    .op_i  (alu_in),
    .res_o (alu_out)
  );

  // Window store: written at the send number, read at the walking send
  // number during a resend.
  gbn_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (WIN_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nsn_q),
    .wdata_i (pkt_data_i),
    .raddr_i (nsn_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    nsn_d    = nsn_q;
    oldest_d = oldest_q;
    expect_d = expect_q;
    count_d  = count_q;
    idx_d    = idx_q;
    rack_d   = rack_q;
    kind_d   = kind_q;
    valid_d  = 1'b0;
    okind_d  = okind_q;
    oseq_d   = oseq_q;
    odata_d  = odata_q;
    ocount_d = ocount_q;
    olast_d  = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_PKT_READY: begin
              valid_d = 1'b1;
              olast_d = 1'b1;
              if (full) begin
                okind_d  = KIND_REFUSED;
                oseq_d   = '0;
                odata_d  = '0;
                ocount_d = count_q;
              end else begin
                okind_d  = KIND_SENT;
                oseq_d   = nsn_q;
                odata_d  = pkt_data_i;
                count_d  = count_q + CNT_W'(1);
                ocount_d = count_q + CNT_W'(1);
                nsn_d    = alu_out.a_inc;
              end
            end
            REQ_FRAME_ARR: begin
              // The inbound number is settled now; the ack is walked next.
              if (rx_seq_i == expect_q) begin
                kind_d   = KIND_RX_OK;
                expect_d = seq_inc(expect_q);
              end else begin
                kind_d = KIND_RX_DROP;
              end
              rack_d  = rx_ack_i;
              state_d = ST_REL;
            end
            REQ_CKSUM_ERR: begin
            end
            REQ_TIMEOUT: begin
              // Rewind to the oldest unacked frame and replay the window.
              nsn_d = oldest_q;
              idx_d = '0;
              if (count_q != '0) begin
                state_d = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REL: begin
        if ((count_q != '0) && alu_out.between) begin
          count_d  = count_q - CNT_W'(1);
          oldest_d = alu_out.a_inc;
        end else begin
          valid_d  = 1'b1;
          okind_d  = kind_q;
          oseq_d   = '0;
          odata_d  = '0;
          ocount_d = count_q;
          olast_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_RD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        valid_d  = 1'b1;
        okind_d  = KIND_SENT;
        oseq_d   = nsn_q;
        odata_d  = ram_rdata;
        ocount_d = count_q;
        olast_d  = (idx_next == count_q);
        nsn_d    = alu_out.a_inc;
        idx_d    = idx_next;
        state_d  = (idx_next == count_q) ? ST_IDLE : ST_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      nsn_q    <= '0;
      oldest_q <= '0;
      expect_q <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      nsn_q    <= nsn_d;
      oldest_q <= oldest_d;
      expect_q <= expect_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rack_q   <= rack_d;
    kind_q   <= kind_d;
    okind_q  <= okind_d;
    oseq_q   <= oseq_d;
    odata_q  <= odata_d;
    ocount_q <= ocount_d;
    olast_q  <= olast_d;
  end

  // The ack field follows the live expected number, which holds still for the cycle in
  // which a result is shown; the window flag is taken from the registered count.
  assign valid_o        = valid_q;
  assign result_kind_o  = okind_q;
  assign tx_seq_o       = oseq_q;
  assign tx_ack_o       = expect_q;
  assign tx_data_o      = odata_q;
  assign window_count_o = ocount_q;
  assign net_enable_o   = (ocount_q < CNT_W'(MAX_SEQ_NUM));
  assign last_o         = olast_q;

  a_emit_strobes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> valid_o)
    else $error("resend emission gave no result");

  a_more_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (state_q == ST_RD))
    else $error("non-final result without a resend in progress");

  a_only_sends_mid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (result_kind_o == KIND_SENT))
    else $error("non-final result is not a sent frame");

  a_resend_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> ((count_q != '0) && (idx_q < count_q)))
    else $error("resend walk outside the buffered window");

endmodule

@@ bench/gbn_link_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and result channels of the Go-Back-N engine, keeps a
// model of its windows and checks every result against it.
module gbn_link_checker import gbn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_o,
  input  logic [1:0]              req_type_i,
  input  logic [PAYLOAD_BITS-1:0] pkt_data_i,
  input  logic [SEQ_W-1:0]        rx_seq_i,
  input  logic [SEQ_W-1:0]        rx_ack_i,
  input  logic                    valid_o,
  input  logic [1:0]              result_kind_o,
  input  logic [SEQ_W-1:0]        tx_seq_o,
  input  logic [SEQ_W-1:0]        tx_ack_o,
  input  logic [PAYLOAD_BITS-1:0] tx_data_o,
  input  logic [CNT_W-1:0]        window_count_o,
  input  logic                    net_enable_o,
  input  logic                    last_o,
  output int unsigned             mismatch_count,
  output int unsigned             frames_pending
);

  typedef struct packed {
    logic [1:0]              kind;
    seq_t                    seq;
    seq_t                    ack;
    logic [PAYLOAD_BITS-1:0] data;
    logic [CNT_W-1:0]        count;
    logic                    enable;
    logic                    last;
  } link_result_t;

  link_result_t            results_due[$];

  // Model of the engine's state.
  seq_t                    send_seq;
  seq_t                    ack_base;
  seq_t                    inbound_seq;
  logic [CNT_W-1:0]        held_frames;
  logic [PAYLOAD_BITS-1:0] payload_store [WIN_DEPTH];

  function automatic seq_t wrap_inc(input seq_t x);
    return (x == SEQ_W'(MAX_SEQ_NUM)) ? seq_t'(0) : seq_t'(x + 1'b1);
  endfunction

  // True when b lies circularly in [a, c).
  function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("checker: %s", msg);
    mismatch_count++;
  endtask

  task automatic queue_result(input logic [1:0] kind, input seq_t seq,
                              input logic [PAYLOAD_BITS-1:0] data, input logic is_last);
    link_result_t r;
    r.kind   = kind;
    r.seq    = seq;
    r.ack    = inbound_seq;
    r.data   = data;
    r.count  = held_frames;
    r.enable = (held_frames < CNT_W'(MAX_SEQ_NUM));
    r.last   = is_last;
    results_due.push_back(r);
  endtask

  task automatic predict_step(input logic [1:0] req, input logic [PAYLOAD_BITS-1:0] data,
                              input seq_t rseq, input seq_t rack);
    logic [1:0] kind;
    case (req)
      REQ_PKT_READY: begin
        if (held_frames >= CNT_W'(MAX_SEQ_NUM)) begin
          queue_result(KIND_REFUSED, '0, '0, 1'b1);
        end else begin
          payload_store[send_seq] = data;
          held_frames = held_frames + 1'b1;
          queue_result(KIND_SENT, send_seq, data, 1'b1);
          send_seq = wrap_inc(send_seq);
        end
      end
      REQ_FRAME_ARR: begin
        kind = KIND_RX_DROP;
        if (rseq == inbound_seq) begin
          kind = KIND_RX_OK;
          inbound_seq = wrap_inc(inbound_seq);
        end
        // Frames are released from the oldest one while the ack lies in the window.
        while (held_frames != 0 && in_window(ack_base, rack, send_seq)) begin
          held_frames = held_frames - 1'b1;
          ack_base = wrap_inc(ack_base);
        end
        queue_result(kind, '0, '0, 1'b1);
      end
      REQ_TIMEOUT: begin
        send_seq = ack_base;
        for (int i = 0; i < held_frames; i++) begin
          queue_result(KIND_SENT, send_seq, payload_store[send_seq], (i + 1 == held_frames));
          send_seq = wrap_inc(send_seq);
        end
      end
      default: begin
        // A checksum error leaves everything as it was.
      end
    endcase
  endtask

  task automatic check_result();
    link_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result of kind %0d with nothing expected", result_kind_o));
      return;
    end
    want = results_due.pop_front();
    if (result_kind_o !== want.kind)
      report_mismatch($sformatf("result_kind %0h, expected %0h", result_kind_o, want.kind));
    if (tx_seq_o !== want.seq)
      report_mismatch($sformatf("tx_seq %0h, expected %0h", tx_seq_o, want.seq));
    if (tx_ack_o !== want.ack)
      report_mismatch($sformatf("tx_ack %0h, expected %0h", tx_ack_o, want.ack));
    if (tx_data_o !== want.data)
      report_mismatch($sformatf("tx_data %0h, expected %0h", tx_data_o, want.data));
    if (window_count_o !== want.count)
      report_mismatch($sformatf("window_count %0h, expected %0h", window_count_o, want.count));
    if (net_enable_o !== want.enable)
      report_mismatch($sformatf("net_enable %0h, expected %0h", net_enable_o, want.enable));
    if (last_o !== want.last)
      report_mismatch($sformatf("last %0h, expected %0h", last_o, want.last));
  endtask

  initial mismatch_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      results_due.delete();
      send_seq       = '0;
      ack_base       = '0;
      inbound_seq    = '0;
      held_frames    = '0;
      frames_pending <= 0;
    end else begin
      // Results are checked before a new item is predicted, so the oldest
      // expectation is always the one compared.
      if (valid_o) check_result();
      if (start_i && !busy_o) predict_step(req_type_i, pkt_data_i, rx_seq_i, rx_ack_i);
      frames_pending <= results_due.size();
    end
  end

endmodule

@@ bench/tb_go_back_n_arq_engine_unit.sv @@
`timescale 1ns / 1ps

// Top level of the bench. It resets the engine once, drives a directed run and
// then random traffic in several idling phases, and gives the verdict. All
// checking is done by the link checker instantiated beside the engine.
module tb_go_back_n_arq_engine_unit;
  import gbn_pkg::*;

  // Cycles with no item accepted and no result shown before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Counted random items per idling phase.
  localparam int unsigned PHASE_ITEMS = 25;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic [1:0]              req_type_i = REQ_CKSUM_ERR;
  logic [PAYLOAD_BITS-1:0] pkt_data_i = '0;
  logic [SEQ_W-1:0]        rx_seq_i = '0;
  logic [SEQ_W-1:0]        rx_ack_i = '0;
  logic                    busy_o;
  logic                    valid_o;
  logic [1:0]              result_kind_o;
  logic [SEQ_W-1:0]        tx_seq_o;
  logic [SEQ_W-1:0]        tx_ack_o;
  logic [PAYLOAD_BITS-1:0] tx_data_o;
  logic [CNT_W-1:0]        window_count_o;
  logic                    net_enable_o;
  logic                    last_o;

  int unsigned             mismatch_count;
  int unsigned             frames_pending;
  int unsigned             quiet_cycles = 0;

  // The sequence number the engine expects next from the far end. The bench
  // keeps it so that most arriving frames are in order and get accepted.
  seq_t                    peer_seq = '0;

  always #1 clk_i = ~clk_i;

  go_back_n_arq_engine_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .pkt_data_i     (pkt_data_i),
    .rx_seq_i       (rx_seq_i),
    .rx_ack_i       (rx_ack_i),
    .valid_o        (valid_o),
    .result_kind_o  (result_kind_o),
    .tx_seq_o       (tx_seq_o),
    .tx_ack_o       (tx_ack_o),
    .tx_data_o      (tx_data_o),
    .window_count_o (window_count_o),
    .net_enable_o   (net_enable_o),
    .last_o         (last_o)
  );

  gbn_link_checker link_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .pkt_data_i     (pkt_data_i),
    .rx_seq_i       (rx_seq_i),
    .rx_ack_i       (rx_ack_i),
    .valid_o        (valid_o),
    .result_kind_o  (result_kind_o),
    .tx_seq_o       (tx_seq_o),
    .tx_ack_o       (tx_ack_o),
    .tx_data_o      (tx_data_o),
    .window_count_o (window_count_o),
    .net_enable_o   (net_enable_o),
    .last_o         (last_o),
    .mismatch_count (mismatch_count),
    .frames_pending (frames_pending)
  );

  // The watchdog is reset by any accepted item or shown result. A hung engine
  // therefore ends the run here rather than letting it spin for ever.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one item and returns at the edge at which it is accepted. The
  // start strobe is deliberately left high so that a following item can go
  // straight out; only the idle and drain tasks lower it.
  task automatic send_item(input logic [1:0] req, input logic [PAYLOAD_BITS-1:0] data,
                           input seq_t seq, input seq_t ack);
    start_i    <= 1'b1;
    req_type_i <= req;
    pkt_data_i <= data;
    rx_seq_i   <= seq;
    rx_ack_i   <= ack;
    // busy_o is read before the engine updates it at this edge.
    do @(posedge clk_i); while (busy_o);
    // An in-order frame moves the engine's expected number on.
    if (req == REQ_FRAME_ARR && seq == peer_seq)
      peer_seq = (peer_seq == SEQ_W'(MAX_SEQ_NUM)) ? seq_t'(0) : seq_t'(peer_seq + 1'b1);
  endtask

  // Holds the sender off for a random run of cycles, with a chance of pct
  // per cent of idling at all and the same chance for every further cycle.
  task automatic sender_gap(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
  endtask

  // Stops sending and waits until every expected result has been shown. The
  // count from the checker is registered, hence a step before each look.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (frames_pending != 0);
  endtask

  // One random item. Packets and in-order frames dominate so that the window
  // fills, wraps and is released; stray frames, checksum errors and timeouts
  // are mixed in. The return value says whether the item counts, since a
  // checksum error is simply ignored by the engine.
  function automatic logic pick_random_item(output logic [1:0] req,
                                            output logic [PAYLOAD_BITS-1:0] data,
                                            output seq_t seq, output seq_t ack);
    int unsigned roll;
    roll = $urandom_range(99);
    data = $urandom;
    seq  = seq_t'($urandom_range(MAX_SEQ_NUM));
    ack  = seq_t'($urandom_range(MAX_SEQ_NUM));
    if ($urandom_range(9) == 0) data = $urandom_range(1) ? '1 : '0;
    if (roll < 45) begin
      req = REQ_PKT_READY;
    end else if (roll < 75) begin
      req = REQ_FRAME_ARR;
      if ($urandom_range(3) != 0) seq = peer_seq;
    end else if (roll < 85) begin
      req = REQ_CKSUM_ERR;
    end else begin
      req = REQ_TIMEOUT;
    end
    return (req != REQ_CKSUM_ERR);
  endfunction

  initial begin
    int unsigned       idle_pct [4];
    int unsigned       counted;
    logic [1:0]        req;
    logic [PAYLOAD_BITS-1:0] data;
    seq_t              seq;
    seq_t              ack;

    idle_pct = '{0, 81, 9, 0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With nothing buffered, a checksum error and a timeout
    // produce no result at all.
    send_item(REQ_CKSUM_ERR, 32'h0000_0000, 3'd0, 3'd0);
    send_item(REQ_TIMEOUT,   32'hFFFF_FFFF, 3'd7, 3'd7);
    // An in-order frame is accepted, then an out-of-order one is discarded.
    send_item(REQ_FRAME_ARR, 32'h0000_0000, 3'd0, 3'd0);
    send_item(REQ_FRAME_ARR, 32'hFFFF_FFFF, 3'd7, 3'd7);
    // Seven packets fill the window; the eighth is refused.
    send_item(REQ_PKT_READY, 32'h0000_0000, 3'd0, 3'd0);
    send_item(REQ_PKT_READY, 32'hFFFF_FFFF, 3'd7, 3'd7);
    send_item(REQ_PKT_READY, 32'hAAAA_AAAA, 3'd0, 3'd0);
    send_item(REQ_PKT_READY, 32'h5555_5555, 3'd0, 3'd0);
    send_item(REQ_PKT_READY, 32'h8000_0000, 3'd0, 3'd0);
    send_item(REQ_PKT_READY, 32'h0000_0001, 3'd0, 3'd0);
    send_item(REQ_PKT_READY, $urandom, 3'd0, 3'd0);
    send_item(REQ_PKT_READY, 32'hDEAD_0BAD, 3'd0, 3'd0);
    // A timeout with a full window resends all seven frames.
    send_item(REQ_TIMEOUT, 32'h0000_0000, 3'd0, 3'd0);
    send_item(REQ_CKSUM_ERR, 32'hFFFF_FFFF, 3'd7, 3'd7);
    // Ack 2 releases the three oldest frames.
    send_item(REQ_FRAME_ARR, 32'h0000_0000, peer_seq, 3'd2);
    // An ack equal to the next send number lies outside the window and
    // releases nothing.
    send_item(REQ_FRAME_ARR, 32'h0000_0000, 3'd7, 3'd7);
    // Two more packets make the send number wrap past the top.
    send_item(REQ_PKT_READY, $urandom, 3'd0, 3'd0);
    send_item(REQ_PKT_READY, $urandom, 3'd0, 3'd0);
    // A timeout across the wrap, then an ack that releases the whole window.
    send_item(REQ_TIMEOUT, 32'h0000_0000, 3'd0, 3'd0);
    send_item(REQ_FRAME_ARR, 32'h0000_0000, peer_seq, 3'd0);
    send_item(REQ_TIMEOUT, 32'h0000_0000, 3'd0, 3'd0);
    send_item(REQ_FRAME_ARR, 32'h0000_0000, 3'd5, 3'd5);
    drain_results();

    // Random part, in phases with different amounts of sender idling. The
    // engine cannot be stalled on its result side, so only the sender idles.
    // Each phase ends by letting every outstanding result come out.
    foreach (idle_pct[p]) begin
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        sender_gap(idle_pct[p]);
        if (pick_random_item(req, data, seq, ack)) counted++;
        send_item(req, data, seq, ack);
      end
      drain_results();
    end

    // Nothing is expected any more; give the engine a little longer in case
    // it shows a stray result, then judge.
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/gbn_pkg.sv
hdl/gbn_ram.sv
hdl/gbn_seq_alu.sv
hdl/go_back_n_arq_engine_unit.sv
bench/gbn_link_checker.sv
bench/tb_go_back_n_arq_engine_unit.sv
